>>> rtl/srt_pkg.sv
// Shared constants, codes and types of the session recency table.
package srt_pkg;

    // Default configuration
    localparam int DEF_TABLE_ENTRIES = 12;
    localparam int DEF_KEY_BITS      = 64;

    // Fixed port and field widths
    localparam int KEY_PORT_W = 64;
    localparam int WORD_W     = 32;
    localparam int SLOT_W     = 4;
    localparam int MODE_W     = 2;

    localparam logic [WORD_W-1:0] WORD_MAX = '1;

    // Item operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_UPSERT = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_READ,
        S_REPLY
    } t_state;

    // Scan control from the sequencer to the match tracker
    typedef struct packed {
        logic start;   // new upsert: forget the previous scan
        logic pend;    // read data of the entry at the compare index is present
    } t_scan_ctl;

endpackage

>>> rtl/srt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srt_ram
    import srt_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word and read one word into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/srt_match.sv
// Scan tracker: first key match and oldest order stamp over the scanned entries.
module srt_match
    import srt_pkg::*;
#(
    parameter int IDX_W    = 4,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_scan_ctl           i_ctl,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [KEY_BITS-1:0] i_row_key,
    input  logic [WORD_W-1:0]   i_row_count,
    input  logic [WORD_W-1:0]   i_row_order,
    output logic                o_match,
    output logic                o_hit,
    output logic [IDX_W-1:0]    o_hit_idx,
    output logic [WORD_W-1:0]   o_hit_count,
    output logic [IDX_W-1:0]    o_min_idx,
    output logic [KEY_BITS-1:0] o_min_key
);

    logic                r_hit;
    logic                r_min_any;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [WORD_W-1:0]   r_hit_count;
    logic [IDX_W-1:0]    r_min_idx;
    logic [WORD_W-1:0]   r_min_order;
    logic [KEY_BITS-1:0] r_min_key;
    logic                take_min;

    assign o_match  = i_ctl.pend && (i_row_key == i_key);
    // strict less keeps the lowest index on equal stamps
    assign take_min = i_ctl.pend && (!r_min_any || (i_row_order < r_min_order));

    // Track control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_min_any <= 1'b0;
        end else if (i_ctl.start) begin
            r_hit     <= 1'b0;
            r_min_any <= 1'b0;
        end else begin
            if (o_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (i_ctl.pend) begin
                r_min_any <= 1'b1;
            end
        end
    end

    // Hold the matched entry and the oldest entry seen so far
    always_ff @(posedge i_clk) begin
        if (o_match && !r_hit) begin
            r_hit_idx   <= i_idx;
            r_hit_count <= i_row_count;
        end
        if (take_min) begin
            r_min_idx   <= i_idx;
            r_min_order <= i_row_order;
            r_min_key   <= i_row_key;
        end
    end

    assign o_hit       = r_hit;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_count = r_hit_count;
    assign o_min_idx   = r_min_idx;
    assign o_min_key   = r_min_key;

endmodule

>>> rtl/session_recency_table_core.sv
// Top level of the session recency table: sequencer, entry memory and scan tracker.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | i_in_valid, o_in_stall | mode, session_key, date/time word, slot
//  out     | output    | o_out_valid, i_out_stall | slot, hit, evicted, entry fields, occupancy
//
//  Upsert: a scan over the used entries, then a write of the chosen entry and the result
//  (an empty table skips the scan); the scan reads one entry a cycle through the
//  memory's single read port and stops early on the first key match.
//  Read, clear and no-op: S_READ or S_REPLY loads the result; the next item is taken the cycle after.
//  One item is in work at a time; o_in_stall is high outside the idle state.
//  The result sits in an output register; a stalled result holds the item in work.
//  Reset (synchronous, active low) empties the table through the fill count; no sweep.
module session_recency_table_core
    import srt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = DEF_KEY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [KEY_PORT_W-1:0] i_session_key,
    input  logic [WORD_W-1:0]     i_date_word,
    input  logic [WORD_W-1:0]     i_time_word,
    input  logic [SLOT_W-1:0]     i_slot_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_hit,
    output logic                  o_evicted,
    output logic [KEY_PORT_W-1:0] o_evicted_key,
    output logic                  o_entry_valid,
    output logic [KEY_PORT_W-1:0] o_entry_key,
    output logic [WORD_W-1:0]     o_entry_count,
    output logic [WORD_W-1:0]     o_entry_order,
    output logic [WORD_W-1:0]     o_entry_date,
    output logic [WORD_W-1:0]     o_entry_time,
    output logic [SLOT_W-1:0]     o_occupancy
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int ROW_W = KEY_BITS + 4 * WORD_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    // Sequencer and table state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_used, n_used;
    logic [WORD_W-1:0]   r_order_ctr, n_order_ctr;
    logic [CNT_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_pend, n_pend;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]    r_sel_idx, n_sel_idx;

    // Item in work
    t_mode               r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [WORD_W-1:0]   r_date;
    logic [WORD_W-1:0]   r_time;
    logic [SLOT_W-1:0]   r_slot;

    // Output register
    logic                r_out_valid;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic                r_out_hit, n_out_hit;
    logic                r_out_evicted, n_out_evicted;
    logic [KEY_BITS-1:0] r_out_ev_key, n_out_ev_key;
    logic                r_out_e_valid, n_out_e_valid;
    logic [KEY_BITS-1:0] r_out_e_key, n_out_e_key;
    logic [WORD_W-1:0]   r_out_e_count, n_out_e_count;
    logic [WORD_W-1:0]   r_out_e_order, n_out_e_order;
    logic [WORD_W-1:0]   r_out_e_date, n_out_e_date;
    logic [WORD_W-1:0]   r_out_e_time, n_out_e_time;
    logic [SLOT_W-1:0]   r_out_occ, n_out_occ;

    // Control and datapath nets
    logic                in_xfer;
    logic                out_free;
    logic                load_out;
    logic                issue;
    logic                full;
    t_scan_ctl           scan_ctl;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ROW_W-1:0]    wr_row;
    logic [ROW_W-1:0]    rd_row;
    logic [KEY_BITS-1:0] rd_key;
    logic [WORD_W-1:0]   rd_count;
    logic [WORD_W-1:0]   rd_order;
    logic [WORD_W-1:0]   rd_date;
    logic [WORD_W-1:0]   rd_time;
    logic                match_now;
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic [WORD_W-1:0]   hit_count;
    logic [IDX_W-1:0]    min_idx;
    logic [KEY_BITS-1:0] min_key;
    logic [IDX_W-1:0]    w_idx;
    logic [WORD_W-1:0]   w_count;
    logic                w_evict;
    logic [CNT_W-1:0]    w_used;

    // Entry memory: key, count, order stamp, date, time in one row
    srt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_row),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_row)
    );

    assign rd_time  = rd_row[WORD_W-1:0];
    assign rd_date  = rd_row[2*WORD_W-1:WORD_W];
    assign rd_order = rd_row[3*WORD_W-1:2*WORD_W];
    assign rd_count = rd_row[4*WORD_W-1:3*WORD_W];
    assign rd_key   = rd_row[ROW_W-1:4*WORD_W];

    srt_match #(
        .IDX_W    (IDX_W),
        .KEY_BITS (KEY_BITS)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_idx       (r_cmp_idx),
        .i_key       (r_key),
        .i_row_key   (rd_key),
        .i_row_count (rd_count),
        .i_row_order (rd_order),
        .o_match     (match_now),
        .o_hit       (hit),
        .o_hit_idx   (hit_idx),
        .o_hit_count (hit_count),
        .o_min_idx   (min_idx),
        .o_min_key   (min_key)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign full       = (r_used == FULL_CNT);
    assign issue      = (r_rd_idx < r_used);

    // Start a fresh scan on an upsert transfer; compare while read data is pending
    assign scan_ctl = '{start: in_xfer && (t_mode'(i_mode) == MODE_UPSERT),
                        pend:  r_pend && (r_state == S_SCAN)};

    // Pick the entry that an upsert writes
    always_comb begin
        w_evict = 1'b0;
        w_used  = r_used;
        if (hit) begin
            w_idx   = hit_idx;
            w_count = (hit_count == WORD_MAX) ? WORD_MAX : hit_count + WORD_W'(1);
        end else if (!full) begin
            w_idx   = r_used[IDX_W-1:0];
            w_count = WORD_W'(1);
            w_used  = r_used + CNT_W'(1);
        end else begin
            w_idx   = min_idx;
            w_count = WORD_W'(1);
            w_evict = 1'b1;
        end
    end

    assign wr_addr = w_idx;
    assign wr_row  = {r_key, w_count, r_order_ctr, r_date, r_time};

    // Sequence the item: next state, memory access and result
    always_comb begin
        n_state        = r_state;
        n_used         = r_used;
        n_order_ctr    = r_order_ctr;
        n_rd_idx       = r_rd_idx;
        n_pend         = 1'b0;
        n_cmp_idx      = r_cmp_idx;
        n_sel_idx      = r_sel_idx;
        rd_addr        = r_sel_idx;
        wr_en          = 1'b0;
        load_out       = 1'b0;
        n_out_slot     = '0;
        n_out_hit      = 1'b0;
        n_out_evicted  = 1'b0;
        n_out_ev_key   = '0;
        n_out_e_valid  = 1'b0;
        n_out_e_key    = '0;
        n_out_e_count  = '0;
        n_out_e_order  = '0;
        n_out_e_date   = '0;
        n_out_e_time   = '0;
        n_out_occ      = SLOT_W'(r_used);
        case (r_state)
            S_IDLE: begin
                rd_addr = IDX_W'(i_slot_index);
                if (in_xfer) begin
                    case (t_mode'(i_mode))
                        MODE_UPSERT: begin
                            n_rd_idx       = '0;
                            n_state        = (r_used == '0) ? S_WRITE : S_SCAN;
                        end
                        MODE_CLEAR: begin
                            n_used      = '0;
                            n_order_ctr = '0;
                            n_state     = S_REPLY;
                        end
                        MODE_READ: begin
                            n_sel_idx = IDX_W'(i_slot_index);
                            if (CMP_W'(i_slot_index) < CMP_W'(r_used)) begin
                                n_state = S_READ;
                            end else begin
                                n_state = S_REPLY;
                            end
                        end
                        default: begin
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read a cycle, compare the one returned
                rd_addr = r_rd_idx[IDX_W-1:0];
                if (scan_ctl.pend && match_now) begin
                    n_state = S_WRITE;
                end else if (issue) begin
                    n_rd_idx  = r_rd_idx + CNT_W'(1);
                    n_pend    = 1'b1;
                    n_cmp_idx = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    wr_en         = 1'b1;
                    load_out      = 1'b1;
                    n_used        = w_used;
                    n_order_ctr   = (r_order_ctr == WORD_MAX) ? WORD_MAX
                                                              : r_order_ctr + WORD_W'(1);
                    n_out_slot    = SLOT_W'(w_idx);
                    n_out_hit     = hit;
                    n_out_evicted = w_evict;
                    n_out_ev_key  = w_evict ? min_key : '0;
                    n_out_e_valid = 1'b1;
                    n_out_e_key   = r_key;
                    n_out_e_count = w_count;
                    n_out_e_order = r_order_ctr;
                    n_out_e_date  = r_date;
                    n_out_e_time  = r_time;
                    n_out_occ     = SLOT_W'(w_used);
                    n_state       = S_IDLE;
                end
            end
            S_READ: begin
                // address held so the read data stays put while the output waits
                if (out_free) begin
                    load_out      = 1'b1;
                    n_out_slot    = r_slot;
                    n_out_e_valid = 1'b1;
                    n_out_e_key   = rd_key;
                    n_out_e_count = rd_count;
                    n_out_e_order = rd_order;
                    n_out_e_date  = rd_date;
                    n_out_e_time  = rd_time;
                    n_state       = S_IDLE;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    n_out_slot = (r_mode == MODE_READ) ? r_slot : '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_order_ctr <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_order_ctr <= n_order_ctr;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the item and hold scan indexes
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_sel_idx <= n_sel_idx;
        if (in_xfer) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_session_key[KEY_BITS-1:0];
            r_date <= i_date_word;
            r_time <= i_time_word;
            r_slot <= i_slot_index;
        end
    end

    // Load the result
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_slot    <= n_out_slot;
            r_out_hit     <= n_out_hit;
            r_out_evicted <= n_out_evicted;
            r_out_ev_key  <= n_out_ev_key;
            r_out_e_valid <= n_out_e_valid;
            r_out_e_key   <= n_out_e_key;
            r_out_e_count <= n_out_e_count;
            r_out_e_order <= n_out_e_order;
            r_out_e_date  <= n_out_e_date;
            r_out_e_time  <= n_out_e_time;
            r_out_occ     <= n_out_occ;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_out_slot;
    assign o_hit         = r_out_hit;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = KEY_PORT_W'(r_out_ev_key);
    assign o_entry_valid = r_out_e_valid;
    assign o_entry_key   = KEY_PORT_W'(r_out_e_key);
    assign o_entry_count = r_out_e_count;
    assign o_entry_order = r_out_e_order;
    assign o_entry_date  = r_out_e_date;
    assign o_entry_time  = r_out_e_time;
    assign o_occupancy   = r_out_occ;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_CNT)
        else $error("fill count beyond table size");

    a_wr_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CNT_W'(wr_addr) <= r_used))
        else $error("write beyond the next free entry");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && n_out_evicted) |-> (full && !hit))
        else $error("replacement while table not full or key present");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_used != '0))
        else $error("scan over an empty table");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the session recency table core with a table predictor.
module tb_top;
    import srt_pkg::*;

    localparam int N_SLOTS = DEF_TABLE_ENTRIES;
    localparam logic [KEY_PORT_W-1:0] KEY_MASK =
        {KEY_PORT_W{1'b1}} >> (KEY_PORT_W - DEF_KEY_BITS);
    localparam int N_RANDOM    = 1250;
    localparam int KEY_POOL_N  = 20;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 150;
    localparam int DRAIN_AT    = 700;
    localparam int TAIL_CYCLES = 2 * N_SLOTS + 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_mode                 mode;
        logic [KEY_PORT_W-1:0] session_key;
        logic [WORD_W-1:0]     date_word;
        logic [WORD_W-1:0]     time_word;
        logic [SLOT_W-1:0]     slot_index;
    } t_log_item;

    typedef struct packed {
        logic [SLOT_W-1:0]     slot;
        logic                  hit;
        logic                  evicted;
        logic [KEY_PORT_W-1:0] evicted_key;
        logic                  entry_valid;
        logic [KEY_PORT_W-1:0] entry_key;
        logic [WORD_W-1:0]     entry_count;
        logic [WORD_W-1:0]     entry_order;
        logic [WORD_W-1:0]     entry_date;
        logic [WORD_W-1:0]     entry_time;
        logic [SLOT_W-1:0]     occupancy;
    } t_table_reply;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [MODE_W-1:0]     i_mode = MODE_NOP;
    logic [KEY_PORT_W-1:0] i_session_key = '0;
    logic [WORD_W-1:0]     i_date_word = '0;
    logic [WORD_W-1:0]     i_time_word = '0;
    logic [SLOT_W-1:0]     i_slot_index = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_hit;
    logic                  o_evicted;
    logic [KEY_PORT_W-1:0] o_evicted_key;
    logic                  o_entry_valid;
    logic [KEY_PORT_W-1:0] o_entry_key;
    logic [WORD_W-1:0]     o_entry_count;
    logic [WORD_W-1:0]     o_entry_order;
    logic [WORD_W-1:0]     o_entry_date;
    logic [WORD_W-1:0]     o_entry_time;
    logic [SLOT_W-1:0]     o_occupancy;

    // Predicted table contents
    logic [KEY_PORT_W-1:0] tbl_key   [N_SLOTS];
    logic [WORD_W-1:0]     tbl_count [N_SLOTS];
    logic [WORD_W-1:0]     tbl_order [N_SLOTS];
    logic [WORD_W-1:0]     tbl_date  [N_SLOTS];
    logic [WORD_W-1:0]     tbl_time  [N_SLOTS];
    bit                    tbl_written [N_SLOTS];
    int unsigned           tbl_used = 0;
    logic [WORD_W-1:0]     tbl_stamp = '0;

    // Stimulus and bookkeeping
    t_log_item             log_items[$];
    t_table_reply          table_replies_due[$];
    logic [KEY_PORT_W-1:0] key_pool [KEY_POOL_N];
    t_log_item             cur_item = '0;
    bit                    offering = 1'b0;
    bit                    item_taken = 1'b0;
    int                    sent_count = 0;
    int                    total_items = 0;
    int                    n_directed = 0;
    int                    drained_at = -1;
    int                    hold_left = 0;
    bit                    hold_done = 1'b0;
    int                    mismatch_count = 0;
    int                    cycle_count = 0;

    session_recency_table_core uut (.*);

    always #6 i_clk = ~i_clk;

    // Copy one stored entry into a reply
    function automatic t_table_reply with_entry(t_table_reply r, int idx);
        r.entry_valid = 1'b1;
        r.entry_key   = tbl_key[idx];
        r.entry_count = tbl_count[idx];
        r.entry_order = tbl_order[idx];
        r.entry_date  = tbl_date[idx];
        r.entry_time  = tbl_time[idx];
        return r;
    endfunction

    // Apply one item to the predicted table and return the reply it causes
    function automatic t_table_reply apply_to_table(t_log_item it);
        t_table_reply          r;
        logic [KEY_PORT_W-1:0] k;
        int                    idx;
        bit                    found;
        r = '0;
        case (it.mode)
            MODE_UPSERT: begin
                k = it.session_key & KEY_MASK;
                idx = 0;
                found = 1'b0;
                // first match among occupied entries
                for (int i = 0; i < tbl_used; i++) begin
                    if (!found && tbl_key[i] == k) begin
                        found = 1'b1;
                        idx = i;
                    end
                end
                if (found) begin
                    r.hit = 1'b1;
                    if (tbl_count[idx] != WORD_MAX) tbl_count[idx]++;
                end else begin
                    if (tbl_used < N_SLOTS) begin
                        idx = tbl_used;
                        tbl_used++;
                    end else begin
                        // replace the oldest stamp, lowest index on a tie
                        for (int i = 1; i < N_SLOTS; i++) begin
                            if (tbl_order[i] < tbl_order[idx]) idx = i;
                        end
                        r.evicted = 1'b1;
                        r.evicted_key = tbl_key[idx];
                    end
                    tbl_key[idx] = k;
                    tbl_count[idx] = WORD_W'(1);
                    tbl_written[idx] = 1'b1;
                end
                tbl_date[idx] = it.date_word;
                tbl_time[idx] = it.time_word;
                tbl_order[idx] = tbl_stamp;
                if (tbl_stamp != WORD_MAX) tbl_stamp++;
                r.slot = SLOT_W'(idx);
                r = with_entry(r, idx);
            end
            MODE_CLEAR: begin
                tbl_used = 0;
                tbl_stamp = '0;
            end
            MODE_READ: begin
                r.slot = it.slot_index;
                if (it.slot_index < tbl_used) r = with_entry(r, it.slot_index);
            end
            default: ;
        endcase
        r.occupancy = SLOT_W'(tbl_used);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic t_log_item make_item(t_mode m, logic [KEY_PORT_W-1:0] k,
                                            logic [WORD_W-1:0] d, logic [WORD_W-1:0] t,
                                            logic [SLOT_W-1:0] s);
        t_log_item it;
        it.mode = m;
        it.session_key = k;
        it.date_word = d;
        it.time_word = t;
        it.slot_index = s;
        return it;
    endfunction

    // Date or time word, missing now and then
    function automatic logic [WORD_W-1:0] pick_word();
        return ($urandom_range(99) < 15) ? '0 : WORD_W'($urandom);
    endfunction

    // Offer items at the falling edge; hold the payload until the transfer
    always @(negedge i_clk) begin
        int send_idle;
        if (i_rst_n) begin
            if (item_taken) begin
                offering = 1'b0;
                item_taken = 1'b0;
            end
            send_idle = (sent_count < total_items / 3) ? 24 :
                        (sent_count < 2 * total_items / 3) ? 50 : 0;
            if ((sent_count == n_directed || sent_count == DRAIN_AT) &&
                drained_at != sent_count) begin
                // pause until every outstanding reply is back
                if (table_replies_due.size() == 0) drained_at = sent_count;
            end else if (!offering && log_items.size() > 0 &&
                         $urandom_range(99) >= send_idle) begin
                cur_item = log_items.pop_front();
                // steer reads away from entries that were never written
                if (cur_item.mode == MODE_READ && cur_item.slot_index < N_SLOTS &&
                    cur_item.slot_index >= tbl_used && !tbl_written[cur_item.slot_index]) begin
                    cur_item.slot_index = (tbl_used > 0) ?
                        SLOT_W'($urandom_range(tbl_used - 1)) :
                        SLOT_W'($urandom_range(15, N_SLOTS));
                end
                offering = 1'b1;
            end
            i_in_valid    <= offering;
            i_mode        <= cur_item.mode;
            i_session_key <= cur_item.session_key;
            i_date_word   <= cur_item.date_word;
            i_time_word   <= cur_item.time_word;
            i_slot_index  <= cur_item.slot_index;
        end
    end

    // Predict each input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            table_replies_due.push_back(apply_to_table(cur_item));
            item_taken = 1'b1;
            sent_count++;
        end
    end

    // Stall the output at random, with one long hold-off
    always @(negedge i_clk) begin
        int recv_idle;
        recv_idle = (sent_count < total_items / 3) ? 50 :
                    (sent_count < 2 * total_items / 3) ? 24 : 0;
        if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && sent_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        i_out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
    end

    // Compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_table_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (table_replies_due.size() == 0) begin
                $error("reply with nothing outstanding: slot %0d", o_slot);
                mismatch_count++;
            end else begin
                want = table_replies_due.pop_front();
                check_field("slot", want.slot, o_slot);
                check_field("hit", want.hit, o_hit);
                check_field("evicted", want.evicted, o_evicted);
                check_field("evicted_key", want.evicted_key, o_evicted_key);
                check_field("entry_valid", want.entry_valid, o_entry_valid);
                check_field("entry_key", want.entry_key, o_entry_key);
                check_field("entry_count", want.entry_count, o_entry_count);
                check_field("entry_order", want.entry_order, o_entry_order);
                check_field("entry_date", want.entry_date, o_entry_date);
                check_field("entry_time", want.entry_time, o_entry_time);
                check_field("occupancy", want.occupancy, o_occupancy);
            end
        end
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("session_recency_table_core test failed");
            $finish;
        end
    end

    initial begin
        int                    pick;
        t_mode                 op;
        logic [KEY_PORT_W-1:0] k;
        for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};

        // Directed: empty reads, no-op, extreme keys and words, fill, replace, clear
        log_items.push_back(make_item(MODE_READ, '0, '0, '0, 4'd12));
        log_items.push_back(make_item(MODE_READ, '1, '1, '1, 4'd15));
        log_items.push_back(make_item(MODE_NOP, '1, '1, '1, 4'd15));
        log_items.push_back(make_item(MODE_UPSERT, '0, '0, '0, '0));
        log_items.push_back(make_item(MODE_UPSERT, '1, '1, '1, '1));
        log_items.push_back(make_item(MODE_UPSERT, '0, 32'd1, '0, '0));
        for (int i = 0; i < N_SLOTS - 2; i++) begin
            log_items.push_back(make_item(MODE_UPSERT, key_pool[i], pick_word(),
                                          pick_word(), '0));
        end
        log_items.push_back(make_item(MODE_UPSERT, key_pool[N_SLOTS - 2], '0, 32'd7, '0));
        log_items.push_back(make_item(MODE_UPSERT, '0, '1, '0, '0));
        log_items.push_back(make_item(MODE_READ, '0, '0, '0, 4'd0));
        log_items.push_back(make_item(MODE_READ, '0, '0, '0, 4'd11));
        log_items.push_back(make_item(MODE_READ, '0, '0, '0, 4'd1));
        log_items.push_back(make_item(MODE_CLEAR, '1, '1, '1, '1));
        log_items.push_back(make_item(MODE_READ, '0, '0, '0, 4'd3));
        log_items.push_back(make_item(MODE_UPSERT, key_pool[0], 32'd5, 32'd6, '0));
        log_items.push_back(make_item(MODE_NOP, {$urandom, $urandom}, '0, '0, 4'd9));
        n_directed = log_items.size();

        // Random: mostly upserts over a small key pool so hits and replacements recur
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(49) == 0) key_pool[$urandom_range(KEY_POOL_N - 1)] =
                {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 66) op = MODE_UPSERT;
            else if (pick < 88) op = MODE_READ;
            else if (pick < 91) op = MODE_CLEAR;
            else op = MODE_NOP;
            k = ($urandom_range(4) == 0) ? {$urandom, $urandom} :
                key_pool[$urandom_range(KEY_POOL_N - 1)];
            log_items.push_back(make_item(op, k, pick_word(), pick_word(),
                                          SLOT_W'($urandom_range(15))));
        end
        total_items = log_items.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all items in, all replies out, then a quiet tail
        while (sent_count < total_items) @(posedge i_clk);
        while (table_replies_due.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("session_recency_table_core test passed");
        end else begin
            $display("session_recency_table_core test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/srt_pkg.sv
rtl/srt_ram.sv
rtl/srt_match.sv
rtl/session_recency_table_core.sv
dv/tb_top.sv
